// ===== rtl/dlbe_pkg.sv =====
// Package for the dense layer backward engine: opcodes, result kinds,
// sizes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
package dlbe_pkg;
  localparam int MaxInputs  = 64;
  localparam int MaxOutputs = 64;
  localparam int FracBits   = 16;
  localparam int IdxW       = 6;
  localparam int CntW       = 7;
  localparam int AddrW      = 12;

  typedef enum logic [2:0] {
    OP_LOAD_W   = 3'd0,
    OP_LOAD_G   = 3'd1,
    OP_LOAD_X   = 3'd2,
    OP_BACKWARD = 3'd3,
    OP_ACCUM    = 3'd4,
    OP_READ_C   = 3'd5,
    OP_READ_B   = 3'd6,
    OP_NONE     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_GRAD = 2'd1,
    KIND_CORR = 2'd2,
    KIND_RSV  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_BW_RD, ST_BW_MUL, ST_BW_ACC, ST_BW_SH, ST_BW_DMUL,
    ST_BW_OUT, ST_AC_RD, ST_AC_MUL, ST_AC_WR, ST_BI_RD, ST_BI_WR, ST_RD_WAIT,
    ST_OUT
  } state_e;

  localparam int CfgInputCount  = 0;
  localparam int CfgOutputCount = 1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] c);
    if (c == '0) return CntW'(1);
    if (c > CntW'(64)) return CntW'(64);
    return c;
  endfunction
endpackage

// ===== rtl/dlbe_mac.sv =====
// Shared signed 32x32 multiplier with a registered product.
// Depends on dlbe_pkg.
`timescale 1ns / 1ps
module dlbe_mac
  import dlbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);
  logic signed [63:0] p_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end
  assign p_o = p_q;
endmodule

// ===== rtl/dense_layer_backprop_engine.sv =====
// Top level of the dense layer backward engine: stores, sequencer, output register.
// Depends on dlbe_pkg and dlbe_mac.
//
// Channel | Direction | Signals
// in      | sink      | in_valid_i/in_ready_o, opcode_i row_i col_i value_i deriv_value_i
// out     | source    | out_valid_o/out_ready_i, kind_o res_row_o res_col_o res_value_o last_o
// cfg     | sink      | cfg_valid_i/cfg_ready_o, cfg_index_i cfg_data_i
//
// Backward and accumulate are sequenced through the one shared multiplier and the
// single-port stores. After reset a clearing pass zeroes both correction stores;
// no item is accepted meanwhile. A stalled output holds the sequencer.
`timescale 1ns / 1ps
module dense_layer_backprop_engine
  import dlbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] deriv_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [5:0]         res_row_o,
  output logic [5:0]         res_col_o,
  output logic signed [31:0] res_value_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  logic signed [31:0] w_mem [4096];
  logic signed [31:0] c_mem [4096];
  logic signed [31:0] g_mem [64];
  logic signed [31:0] x_mem [64];
  logic signed [31:0] d_mem [64];
  logic signed [31:0] b_mem [64];

  state_e state_q, state_d;
  logic [CntW-1:0] ni_q, no_q;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic [AddrW:0] clr_q, clr_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] w_rd_q, c_rd_q, g_rd_q, x_rd_q, d_rd_q, b_rd_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic mul_en;
  logic [2:0] op_q;

  logic ov_q, ov_d, olast_q, olast_d;
  logic [1:0] okind_q, okind_d;
  logic [5:0] orow_q, orow_d, ocol_q, ocol_d;
  logic signed [31:0] oval_q, oval_d;

  logic [CntW-1:0] ni_c, no_c;
  assign ni_c = clamp_cnt(ni_q);
  assign no_c = clamp_cnt(no_q);

  logic in_fire;
  assign in_ready_o  = (state_q == ST_IDLE) && !ov_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  dlbe_mac u_mac (.clk_i(clk_i), .en_i(mul_en), .a_i(ma), .b_i(mb), .p_o(prod));

  logic [AddrW-1:0] addr_ij;
  assign addr_ij = {i_q, j_q};

  // Stores: single read address per cycle, registered read data.
  logic c_we;
  logic [AddrW-1:0] c_wa;
  logic signed [31:0] c_wd;
  logic b_we;
  logic [IdxW-1:0] b_wa;
  logic signed [31:0] b_wd;
  always_ff @(posedge clk_i) begin
    if (in_fire && opcode_i == OP_LOAD_W) w_mem[{row_i, col_i}] <= value_i;
    if (in_fire && opcode_i == OP_LOAD_G) g_mem[col_i] <= value_i;
    if (in_fire && opcode_i == OP_LOAD_X) begin
      x_mem[row_i] <= value_i;
      d_mem[row_i] <= deriv_value_i;
    end
    if (c_we) c_mem[c_wa] <= c_wd;
    if (b_we) b_mem[b_wa] <= b_wd;
    w_rd_q <= w_mem[addr_ij];
    c_rd_q <= c_mem[(state_q == ST_IDLE) ? {row_i, col_i} : addr_ij];
    b_rd_q <= b_mem[(state_q == ST_IDLE) ? col_i : j_q];
    g_rd_q <= g_mem[j_q];
    x_rd_q <= x_mem[i_q];
    d_rd_q <= d_mem[i_q];
  end

  logic signed [63:0] fl;
  logic signed [63:0] sum65;
  logic signed [64:0] wide;
  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; clr_d = clr_q; acc_d = acc_q;
    ov_d = ov_q; okind_d = okind_q; orow_d = orow_q; ocol_d = ocol_q;
    oval_d = oval_q; olast_d = olast_q;
    mul_en = 1'b0; ma = g_rd_q; mb = w_rd_q;
    c_we = 1'b0; c_wa = addr_ij; c_wd = '0; b_we = 1'b0; b_wa = j_q; b_wd = '0;
    fl = prod >>> FracBits;
    wide = {acc_q[63], acc_q} + {prod[63], prod};
    sum65 = (wide[64] != wide[63]) ? (wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                                   : wide[63:0];
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        c_we = 1'b1; c_wa = clr_q[AddrW-1:0];
        b_we = 1'b1; b_wa = clr_q[IdxW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q[AddrW-1:0] == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          i_d = '0; j_d = '0; acc_d = '0;
          okind_d = KIND_ACK; orow_d = '0; ocol_d = '0; oval_d = '0; olast_d = 1'b1;
          case (opcode_i)
            OP_LOAD_W, OP_LOAD_G, OP_LOAD_X: state_d = ST_OUT;
            OP_BACKWARD: state_d = ST_BW_RD;
            OP_ACCUM: state_d = ST_AC_RD;
            OP_READ_C: begin
              okind_d = KIND_CORR; orow_d = row_i; ocol_d = col_i;
              state_d = ST_RD_WAIT;
            end
            OP_READ_B: begin
              okind_d = KIND_CORR; ocol_d = col_i;
              state_d = ST_RD_WAIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT: begin
        oval_d = (op_q == OP_READ_B) ? b_rd_q : c_rd_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q) begin
          ov_d = 1'b1; state_d = ST_IDLE;
        end
      end
      ST_BW_RD: state_d = ST_BW_MUL;
      ST_BW_MUL: begin
        mul_en = 1'b1; state_d = ST_BW_ACC;
      end
      ST_BW_ACC: begin
        acc_d = sum65;
        if ({1'b0, j_q} == no_c - 1'b1) begin
          j_d = '0; state_d = ST_BW_SH;
        end else begin
          j_d = j_q + 1'b1; state_d = ST_BW_RD;
        end
      end
      ST_BW_SH: begin
        ma = sat32(acc_q >>> FracBits); mb = d_rd_q; mul_en = 1'b1;
        state_d = ST_BW_DMUL;
      end
      ST_BW_DMUL: state_d = ST_BW_OUT;
      ST_BW_OUT: begin
        if (!ov_q) begin
          ov_d = 1'b1; okind_d = KIND_GRAD; orow_d = i_q; ocol_d = '0;
          oval_d = sat32(fl);
          olast_d = ({1'b0, i_q} == ni_c - 1'b1);
          acc_d = '0;
          if (olast_d) state_d = ST_IDLE;
          else begin
            i_d = i_q + 1'b1; state_d = ST_BW_RD;
          end
        end
      end
      ST_AC_RD: state_d = ST_AC_MUL;
      ST_AC_MUL: begin
        ma = x_rd_q; mb = g_rd_q; mul_en = 1'b1; state_d = ST_AC_WR;
      end
      ST_AC_WR: begin
        c_we = 1'b1;
        c_wd = sat32({{32{c_rd_q[31]}}, c_rd_q} + fl);
        if ({1'b0, j_q} == no_c - 1'b1) begin
          j_d = '0;
          if ({1'b0, i_q} == ni_c - 1'b1) begin
            i_d = '0; state_d = ST_BI_RD;
          end else begin
            i_d = i_q + 1'b1; state_d = ST_AC_RD;
          end
        end else begin
          j_d = j_q + 1'b1; state_d = ST_AC_RD;
        end
      end
      ST_BI_RD: state_d = ST_BI_WR;
      ST_BI_WR: begin
        b_we = 1'b1;
        b_wd = sat32({{32{b_rd_q[31]}}, b_rd_q} + {{32{g_rd_q[31]}}, g_rd_q});
        if ({1'b0, j_q} == no_c - 1'b1) state_d = ST_OUT;
        else begin
          j_d = j_q + 1'b1; state_d = ST_BI_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; ov_q <= 1'b0;
      ni_q <= CntW'(64); no_q <= CntW'(64); i_q <= '0; j_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; ov_q <= ov_d; i_q <= i_d; j_q <= j_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == 1'(CfgInputCount)) ni_q <= cfg_data_i;
        else no_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; okind_q <= okind_d; orow_q <= orow_d; ocol_q <= ocol_d;
    oval_q <= oval_d; olast_q <= olast_d;
    if (in_fire) begin
      op_q <= opcode_i;
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o      = okind_q;
  assign res_row_o   = orow_q;
  assign res_col_o   = ocol_q;
  assign res_value_o = oval_q;
  assign last_o      = olast_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode_i != OP_NONE) |=> !in_ready_o)
    else $error("item accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(oval_q)))
    else $error("result changed while stalled");
  a_ack_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && okind_q == KIND_ACK) |-> (oval_q == '0 && olast_q))
    else $error("acknowledge carries data");
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o) else $error("accept during clear");
endmodule
